// ===== rtl/pts_pkg.sv =====
`default_nettype none

package pts_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes (paddr[2])
    localparam logic REG_POLICY_MODE = 1'b0;
    localparam logic REG_JOB_COUNT   = 1'b1;

    // Pick policies; the unused code behaves as priority
    localparam logic [1:0] MODE_PRIO = 2'd0;
    localparam logic [1:0] MODE_SRT  = 2'd1;
    localparam logic [1:0] MODE_LRT  = 2'd2;

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration seen by the scheduler core
    typedef struct packed {
        logic [1:0] policy_mode;
        logic [4:0] job_count;
    } pts_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pts_apb_regs.sv =====
`default_nettype none

module pts_apb_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pts_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [pts_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output pts_pkg::pts_cfg_t                   cfg
);
    import pts_pkg::*;

    logic [1:0] policy_mode_reg;
    logic [4:0] job_count_reg;
    logic       reg_idx;
    logic       wr_hit;

    assign reg_idx = paddr[2];
    assign wr_hit  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg <= MODE_PRIO;
            job_count_reg   <= 5'd16;
        end
        else if (wr_hit)
        begin
            case (reg_idx)
                REG_POLICY_MODE: policy_mode_reg <= pwdata[1:0];
                REG_JOB_COUNT:   job_count_reg   <= pwdata[4:0];
                default:         ;
            endcase
        end
    end

    // Return register contents on read
    always_comb
    begin
        case (reg_idx)
            REG_POLICY_MODE: prdata = {{(CFG_DATA_W-2){1'b0}}, policy_mode_reg};
            REG_JOB_COUNT:   prdata = {{(CFG_DATA_W-5){1'b0}}, job_count_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.policy_mode = policy_mode_reg;
    assign cfg.job_count   = job_count_reg;

endmodule

`default_nettype wire

// ===== rtl/preemptive_tick_scheduler.sv =====
`default_nettype none

// Channel   Direction  Handshake            Beat
// in        in         in_valid/in_stall    kind, slot, job_id, arrival, burst, prio
// out       out        out_valid/out_stall  idle, running_job, running_slot, finished,
//                                           turnaround, waiting, all_done
// cfg       in         APB psel/penable     policy_mode (0x0), job_count (0x4)
//
// A load beat produces no result. A tick beat, N = min(job_count, MAX_JOBS): the compare
// unit sweeps the first N slots of the slot memory through its registered read port and
// compares each entry read, then passes through the update state and the result state,
// where the result is registered once no earlier result is unclaimed; the next beat is taken in the cycle after.
// Reset clears the slot valid bits, the tick counter and all control state at once.
// out_stall parks the core in its result cycle only while an earlier result is unclaimed.

module preemptive_tick_scheduler #(
    parameter int MAX_JOBS  = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           kind,
    input  wire logic [3:0]                     slot,
    input  wire logic [7:0]                     job_id,
    input  wire logic [15:0]                    arrival,
    input  wire logic [15:0]                    burst,
    input  wire logic [7:0]                     prio,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                idle,
    output logic      [7:0]                     running_job,
    output logic      [3:0]                     running_slot,
    output logic                                finished,
    output logic      [15:0]                    turnaround,
    output logic      [15:0]                    waiting,
    output logic                                all_done,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pts_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [pts_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import pts_pkg::*;

    localparam int SLOT_W = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam logic [TIME_BITS-1:0] TICK_MAX = {TIME_BITS{1'b1}};

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;
    localparam logic [1:0] S_RES   = 2'd3;

    typedef struct packed {
        logic [7:0]           job_id;
        logic [7:0]           prio;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] burst;
        logic [TIME_BITS-1:0] remaining;
    } slot_entry_t;

    function automatic logic [15:0] sat16(input logic [TIME_BITS-1:0] v);
        return (32'(v) > 32'h0000_FFFF) ? 16'hFFFF : 16'(v);
    endfunction

    pts_cfg_t cfg;

    // Slot memory and its read port
    slot_entry_t mem [MAX_JOBS];
    slot_entry_t rd_data_reg;
    logic        rd_vld_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic        mem_we;
    logic [SLOT_W-1:0] mem_wa;
    slot_entry_t mem_wd;

    // Control state
    logic [1:0]          state_reg, state_next;
    logic [MAX_JOBS-1:0] slot_valid_reg;
    logic [TIME_BITS-1:0] tick_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                cmp_valid_reg;
    logic [SLOT_W-1:0]   cmp_idx_reg;
    logic                found_reg;
    logic [CNT_W-1:0]    live_cnt_reg;

    // Pick and result payload
    logic [TIME_BITS-1:0] best_key_reg;
    logic [SLOT_W-1:0]    pick_reg;
    slot_entry_t          best_entry_reg;
    logic [TIME_BITS-1:0] full_reg;
    logic                 fin_reg;
    logic                 all_done_reg;

    logic                 out_valid_reg;
    logic                 idle_reg;
    logic [7:0]           running_job_reg;
    logic [3:0]           running_slot_reg;
    logic                 finished_reg;
    logic [15:0]          turnaround_reg;
    logic [15:0]          waiting_reg;
    logic                 out_all_done_reg;

    // Combinational helpers
    logic                 in_accept;
    logic                 load_ok;
    logic [CNT_W-1:0]     n_act;
    logic                 sweep_issue;
    logic                 sweep_done;
    logic [TIME_BITS-1:0] eff_rem;
    logic [TIME_BITS-1:0] cand_key;
    logic                 cand_live;
    logic                 cand_elig;
    logic                 cand_better;
    logic [TIME_BITS-1:0] rem_dec;
    logic                 fin_now;
    logic [TIME_BITS-1:0] tick_inc;
    logic [TIME_BITS-1:0] full_now;
    logic [CNT_W-1:0]     live_left;
    logic                 res_load;
    logic [15:0]          wait_now;

    pts_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake and counted slots
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign load_ok   = 32'(slot) < MAX_JOBS;
    assign n_act     = (32'(cfg.job_count) > MAX_JOBS) ? CNT_W'(MAX_JOBS)
                                                       : CNT_W'(cfg.job_count);

    // Sweep control: issue one read a cycle, compare the previous one
    assign sweep_issue = (rd_idx_reg < n_act);
    assign sweep_done  = !sweep_issue && !cmp_valid_reg;
    assign rd_addr     = rd_idx_reg[SLOT_W-1:0];

    // Candidate evaluation; a slot never loaded reads as finished
    assign eff_rem   = rd_vld_reg ? rd_data_reg.remaining : '0;
    assign cand_key  = (cfg.policy_mode == MODE_SRT || cfg.policy_mode == MODE_LRT)
                       ? eff_rem : TIME_BITS'(rd_data_reg.prio);
    assign cand_live = cmp_valid_reg && (eff_rem != '0);
    assign cand_elig = cand_live && (rd_data_reg.arrival <= tick_reg);
    assign cand_better = !found_reg ||
                         ((cfg.policy_mode == MODE_LRT) ? (cand_key > best_key_reg)
                                                        : (cand_key < best_key_reg));

    // Update-cycle arithmetic
    assign rem_dec   = best_entry_reg.remaining - 1'b1;
    assign fin_now   = found_reg && (rem_dec == '0);
    assign tick_inc  = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;
    assign full_now  = (tick_inc >= best_entry_reg.arrival)
                       ? tick_inc - best_entry_reg.arrival : '0;
    assign live_left = live_cnt_reg - CNT_W'(fin_now);

    // Result-cycle arithmetic
    assign wait_now = (full_reg >= best_entry_reg.burst)
                      ? sat16(full_reg - best_entry_reg.burst) : 16'd0;
    assign res_load = (state_reg == S_RES) && (!out_valid_reg || !out_stall);

    // Memory write port: loads in idle, write-back after a pick
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = SLOT_W'(slot);
        mem_wd = '{job_id: job_id, prio: prio, arrival: TIME_BITS'(arrival),
                   burst: TIME_BITS'(burst), remaining: TIME_BITS'(burst)};
        case (state_reg)
            S_IDLE:
            begin
                mem_we = in_accept && (kind == KIND_LOAD) && load_ok;
            end
            S_UPD:
            begin
                mem_we           = found_reg;
                mem_wa           = pick_reg;
                mem_wd           = best_entry_reg;
                mem_wd.remaining = rem_dec;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= slot_valid_reg[rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && kind == KIND_TICK)
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:   state_next = S_RES;
            S_RES:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            tick_reg       <= '0;
            rd_idx_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            live_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    rd_idx_reg    <= '0;
                    cmp_valid_reg <= 1'b0;
                    found_reg     <= 1'b0;
                    live_cnt_reg  <= '0;
                    if (in_accept && kind == KIND_LOAD && load_ok)
                    begin
                        slot_valid_reg[SLOT_W'(slot)] <= 1'b1;
                    end
                end
                S_SWEEP:
                begin
                    cmp_valid_reg <= sweep_issue;
                    if (sweep_issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (cand_live)
                    begin
                        live_cnt_reg <= live_cnt_reg + 1'b1;
                    end
                    if (cand_elig && cand_better)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                S_UPD:
                begin
                    tick_reg <= tick_inc;
                end
                default: ;
            endcase
            // Hold the result beat until the far side takes it
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Tracking of the pick and the result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SWEEP)
        begin
            cmp_idx_reg <= rd_addr;
            if (cand_elig && cand_better)
            begin
                best_key_reg   <= cand_key;
                pick_reg       <= cmp_idx_reg;
                best_entry_reg <= rd_data_reg;
            end
        end
        if (state_reg == S_UPD)
        begin
            full_reg     <= full_now;
            fin_reg      <= fin_now;
            all_done_reg <= (live_left == '0);
        end
        if (res_load)
        begin
            idle_reg         <= !found_reg;
            running_job_reg  <= found_reg ? best_entry_reg.job_id : 8'd0;
            running_slot_reg <= found_reg ? 4'(pick_reg) : 4'd0;
            finished_reg     <= fin_reg;
            turnaround_reg   <= fin_reg ? sat16(full_reg) : 16'd0;
            waiting_reg      <= fin_reg ? wait_now : 16'd0;
            out_all_done_reg <= all_done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign idle         = idle_reg;
    assign running_job  = running_job_reg;
    assign running_slot = running_slot_reg;
    assign finished     = finished_reg;
    assign turnaround   = turnaround_reg;
    assign waiting      = waiting_reg;
    assign all_done     = out_all_done_reg;

    // An idle beat carries no job and no completion
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!idle || (!finished && running_job == 8'd0 && turnaround == 16'd0)))
        else $error("idle beat carries job data");

    // Time never runs backwards
    a_tick_mono: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg >= $past(tick_reg))
        else $error("tick counter went backwards");

    // The sweep never reads past the counted slots
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (rd_idx_reg <= n_act))
        else $error("sweep ran past the counted slots");

    // Time changes only in the update cycle, at most once per tick beat
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPD) |=> $stable(tick_reg))
        else $error("tick changed outside the update cycle");

    // A write-back only follows a pick
    a_wb_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && mem_we) |-> (found_reg && best_entry_reg.remaining != '0))
        else $error("write-back without a live pick");

endmodule

`default_nettype wire
